@@ hdl/spet_pkg.sv @@
// Shared types and constants for the speech endpoint tracker.
// Holds the endpointer state and event encodings, the configuration register set
// and the per-frame result record. It has no dependencies.
package spet_pkg;

    localparam int FRAME_W  = 31;
    localparam int MARK_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 16;
    localparam int LAT_W    = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_BEGIN  = 3'd1,
        ST_SPEECH = 3'd2,
        ST_ENDING = 3'd3,
        ST_CANCEL = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_START  = 2'd1,
        EV_END    = 2'd2,
        EV_CANCEL = 2'd3
    } event_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PAD_BEFORE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_AFTER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAMES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FRAMES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CANCEL_FRAMES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_LATENCY = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] pad_before;
        logic [CFG_W-1:0] pad_after;
        logic [CFG_W-1:0] start_frames;
        logic [CFG_W-1:0] end_frames;
        logic [CFG_W-1:0] cancel_frames;
        logic [LAT_W-1:0] class_latency;
    } cfg_t;

    typedef struct packed {
        mode_t               state_now;
        event_t              event_code;
        logic [COUNT_W-1:0]  utterance_count;
        logic [MARK_W-1:0]   first_mark;
        logic [MARK_W-1:0]   second_mark;
    } result_t;

endpackage

@@ hdl/spet_core.sv @@
// Endpointer state machine and frame-mark arithmetic for one classified frame.
// Depends on spet_pkg for the state, event, configuration and result types.
// State advances on step_en; the result is combinational from the current frame.
module spet_core import spet_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               step_en,
    input  logic [FRAME_W-1:0] frame_number,
    input  logic               is_speech,
    output result_t            result
);

    mode_t              mode_reg, mode_next;
    logic [MARK_W-1:0]  begin_reg, begin_next;
    logic [MARK_W-1:0]  end_reg, end_next;
    logic [MARK_W-1:0]  leader_reg, leader_next;
    logic [MARK_W-1:0]  trailer_reg, trailer_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [MARK_W-1:0]  frame_ext;
    logic [MARK_W-1:0]  begin_calc;
    logic [MARK_W-1:0]  end_calc;
    logic signed [MARK_W+1:0] begin_run;
    logic signed [MARK_W+1:0] end_run;
    logic               start_met;
    logic               end_met;
    logic               cancel_met;
    event_t             event_code;
    logic [MARK_W-1:0]  first_mark;
    logic [MARK_W-1:0]  second_mark;

    // Candidate marks, corrected for the classifier delay.
    assign frame_ext  = {1'b0, frame_number};
    assign begin_calc = frame_ext - {{(MARK_W-LAT_W){1'b0}}, cfg.class_latency};
    assign end_calc   = begin_calc - MARK_W'(1);

    // Exact run lengths: unsigned frame minus a signed mark, two guard bits.
    assign begin_run = $signed({3'b000, frame_number})
                     - $signed({{2{begin_reg[MARK_W-1]}}, begin_reg});
    assign end_run   = $signed({3'b000, frame_number})
                     - $signed({{2{end_reg[MARK_W-1]}}, end_reg});

    assign start_met  = begin_run >= $signed({{(MARK_W+2-CFG_W){1'b0}}, cfg.start_frames});
    assign end_met    = end_run >= $signed({{(MARK_W+2-CFG_W){1'b0}}, cfg.end_frames});
    assign cancel_met = end_run >= $signed({{(MARK_W+2-CFG_W){1'b0}}, cfg.cancel_frames});

    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            ST_IDLE: begin
                if (is_speech) mode_next = ST_BEGIN;
            end
            ST_BEGIN: begin
                if (!is_speech)     mode_next = ST_CANCEL;
                else if (start_met) mode_next = ST_SPEECH;
            end
            ST_SPEECH: begin
                if (!is_speech) mode_next = ST_ENDING;
            end
            ST_ENDING: begin
                if (is_speech)    mode_next = ST_SPEECH;
                else if (end_met) mode_next = ST_IDLE;
            end
            ST_CANCEL: begin
                if (is_speech)       mode_next = ST_BEGIN;
                else if (cancel_met) mode_next = ST_IDLE;
            end
            default: begin
                mode_next = is_speech ? ST_BEGIN : ST_IDLE;
            end
        endcase
    end

    always_comb begin
        begin_next   = begin_reg;
        end_next     = end_reg;
        leader_next  = leader_reg;
        trailer_next = trailer_reg;
        count_next   = count_reg;
        event_code   = EV_NONE;
        first_mark   = '0;
        second_mark  = '0;
        unique case (mode_reg)
            ST_BEGIN: begin
                if (!is_speech) end_next = end_calc;
            end
            ST_SPEECH: begin
                if (!is_speech) begin
                    end_next     = end_calc;
                    trailer_next = end_calc + {{(MARK_W-CFG_W){1'b0}}, cfg.pad_after};
                end
            end
            ST_ENDING: begin
                if (!is_speech && end_met) begin
                    event_code  = EV_END;
                    first_mark  = end_reg;
                    second_mark = trailer_reg;
                end
            end
            ST_CANCEL: begin
                if (!is_speech && cancel_met) begin
                    event_code = EV_CANCEL;
                    first_mark = end_reg;
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            default: begin
                // Idle, and any unexpected code, which behaves as idle.
                if (is_speech) begin
                    begin_next  = begin_calc;
                    leader_next = begin_calc - {{(MARK_W-CFG_W){1'b0}}, cfg.pad_before};
                    count_next  = count_reg + COUNT_W'(1);
                    event_code  = EV_START;
                    first_mark  = leader_next;
                    second_mark = begin_calc;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= ST_IDLE;
            count_reg <= '0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            begin_reg   <= '0;
            end_reg     <= '0;
            leader_reg  <= '0;
            trailer_reg <= '0;
        end else if (step_en) begin
            begin_reg   <= begin_next;
            end_reg     <= end_next;
            leader_reg  <= leader_next;
            trailer_reg <= trailer_next;
        end
    end

    assign result.state_now       = mode_next;
    assign result.event_code      = event_code;
    assign result.utterance_count = count_next;
    assign result.first_mark      = first_mark;
    assign result.second_mark     = second_mark;

endmodule

@@ hdl/speech_endpoint_tracker.sv @@
// Speech endpoint tracker: throughput is one frame per cycle while m_ready is high.
// A frame register feeds the state machine, whose result is caught in an output
// register, so one beat can wait on each side.
// aresetn is synchronous and active low; it clears the configuration registers,
// the endpointer state (idle), the utterance count and both valid flags.
// Depends on spet_pkg and spet_core.
module speech_endpoint_tracker import spet_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,

    // Frame input channel.
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FRAME_W-1:0]   s_frame_number,
    input  logic                 s_is_speech,

    // Result channel.
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_state_now,
    output logic [1:0]           m_event_code,
    output logic [COUNT_W-1:0]   m_utterance_count,
    output logic signed [MARK_W-1:0] m_first_mark,
    output logic signed [MARK_W-1:0] m_second_mark
);

    cfg_t               cfg_reg;

    // Frame register: holds one accepted beat until the output register frees up.
    logic               in_vld_reg, in_vld_next;
    logic [FRAME_W-1:0] frame_reg;
    logic               speech_reg;

    // Output register.
    logic               out_vld_reg, out_vld_next;
    result_t            out_reg;

    result_t            core_result;
    logic               out_free;
    logic               step;
    logic               in_take;

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PAD_BEFORE:    cfg_reg.pad_before    <= cfg_wdata;
                CFG_PAD_AFTER:     cfg_reg.pad_after     <= cfg_wdata;
                CFG_START_FRAMES:  cfg_reg.start_frames  <= cfg_wdata;
                CFG_END_FRAMES:    cfg_reg.end_frames    <= cfg_wdata;
                CFG_CANCEL_FRAMES: cfg_reg.cancel_frames <= cfg_wdata;
                CFG_CLASS_LATENCY: cfg_reg.class_latency <= cfg_wdata[LAT_W-1:0];
                default: ;
            endcase
        end
    end

    // The output register can take a new result when it is empty or being drained.
    // The state machine steps exactly when a held frame moves into it, so every
    // frame updates the state once and yields exactly one result.
    assign out_free = !out_vld_reg || m_ready;
    assign step     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;
    assign in_take  = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (in_take)   in_vld_next = 1'b1;
        else if (step) in_vld_next = 1'b0;
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (step)         out_vld_next = 1'b1;
        else if (m_ready) out_vld_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            frame_reg  <= s_frame_number;
            speech_reg <= s_is_speech;
        end
        if (step) begin
            out_reg <= core_result;
        end
    end

    spet_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .step_en      (step),
        .frame_number (frame_reg),
        .is_speech    (speech_reg),
        .result       (core_result)
    );

    assign m_valid           = out_vld_reg;
    assign m_state_now       = out_reg.state_now;
    assign m_event_code      = out_reg.event_code;
    assign m_utterance_count = out_reg.utterance_count;
    assign m_first_mark      = $signed(out_reg.first_mark);
    assign m_second_mark     = $signed(out_reg.second_mark);

    // The input side only stalls when both registers are full and the sink waits.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    // A start event always leaves the endpointer in the begin state.
    a_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_code == EV_START) |-> (m_state_now == ST_BEGIN))
        else $error("start event without begin state");

    // End and cancel events always return the endpointer to idle.
    a_close_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_code == EV_END || m_event_code == EV_CANCEL))
            |-> (m_state_now == ST_IDLE))
        else $error("closing event without idle state");

    // A frame stepped into the output register shows up as a valid result next cycle.
    a_step_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("stepped frame produced no result");

endmodule
